### rtl/text_console_writer_unit_defines.svh
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tcw_pkg.sv
// Shared constants, types and helper functions of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int IN_COL_W = 7;
    localparam int IN_ROW_W = 5;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;

    localparam int IN_CHAR_LSB = CMD_W;
    localparam int IN_ATTR_LSB = IN_CHAR_LSB + CHAR_W;
    localparam int IN_COL_LSB  = IN_ATTR_LSB + ATTR_W;
    localparam int IN_ROW_LSB  = IN_COL_LSB + IN_COL_W;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - CELL_W - 1;
    localparam int OUT_SCROLL_BIT = POS_W + CELL_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BACKSPACE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SETCUR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR     = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CHAR       = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_CLEAR_ATTR = 8'h17;
    localparam logic [ATTR_W-1:0] RESET_ERASE_ATTR = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL       = {RESET_CLEAR_ATTR, SPACE_CHAR};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_SETCUR,
        OP_READ,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [CHAR_W-1:0]   char_code;
        logic [ATTR_W-1:0]   attribute;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } op_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } result_t;

    typedef struct packed {
        logic              init;
        logic              busy;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
    } back_status_t;

    function automatic logic [COL_W-1:0] sat_col(input logic [IN_COL_W-1:0] v);
        if (int'(v) >= COLS)
        begin
            return COL_W'(COLS - 1);
        end
        return COL_W'(v);
    endfunction

    function automatic logic [ROW_W-1:0] sat_row(input logic [IN_ROW_W-1:0] v);
        if (int'(v) >= ROWS)
        begin
            return ROW_W'(ROWS - 1);
        end
        return ROW_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

    function automatic logic [POS_W-1:0] to_pos(input logic [ADDR_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### rtl/tcw_front.sv
// Input side: accepts command beats, decodes them and saturates coordinates.
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                  q_full,
    input  wire logic                  hold,
    output logic                       push,
    output op_t                        push_op
);

    logic [CMD_W-1:0]    cmd;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
    logic [IN_COL_W-1:0] col_in;
    logic [IN_ROW_W-1:0] row_in;

    assign cmd    = s_axis_tdata[CMD_W-1:0];
    assign ch     = s_axis_tdata[IN_CHAR_LSB +: CHAR_W];
    assign attr   = s_axis_tdata[IN_ATTR_LSB +: ATTR_W];
    assign col_in = s_axis_tdata[IN_COL_LSB +: IN_COL_W];
    assign row_in = s_axis_tdata[IN_ROW_LSB +: IN_ROW_W];

    assign s_axis_tready = !q_full && !hold;
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        push_op.char_code = ch;
        push_op.attribute = attr;
        push_op.col       = sat_col(col_in);
        push_op.row       = sat_row(row_in);
        unique case (cmd)
            CMD_PUT:       push_op.kind = (ch == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            CMD_BACKSPACE: push_op.kind = OP_BACKSPACE;
            CMD_CLEAR:     push_op.kind = OP_CLEAR;
            CMD_SETCUR:    push_op.kind = OP_SETCUR;
            CMD_READ:      push_op.kind = OP_READ;
            default:       push_op.kind = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

### rtl/tcw_queue.sv
// Short queue of decoded commands between the input side and the executing side.
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    input  wire logic pop,
    output op_t       pop_op,
    output logic      empty,
    output logic      full
);

    op_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_op = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

### rtl/tcw_back.sv
// Executing side: owns the cursor and the screen store, runs sweeps and holds the result.
`default_nettype none

module tcw_back
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire op_t               q_op,
    output logic                   q_pop,
    input  wire logic [ATTR_W-1:0] clear_attr,
    input  wire logic [ATTR_W-1:0] erase_attr,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output result_t                m_result,
    output back_status_t           status
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_FILL   = 5'b01000,
        ST_SCROLL = 5'b10000
    } back_state_t;

    localparam logic [ADDR_W-1:0] SCROLL_LEN = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CELL_W-1:0]  fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               slot_free;
    logic               load;
    logic               load_scrolled;
    logic [CELL_W-1:0]  load_cell;
    logic [ADDR_W-1:0]  cur_addr;
    logic               last_col;
    logic               last_row;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [CELL_W-1:0]  wdata;
    logic [ADDR_W-1:0]  raddr;
    logic [CELL_W-1:0]  rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_free = !out_valid_reg || m_ready;
    assign cur_addr  = cell_addr(row_reg, col_reg);
    assign last_col  = (col_reg == COL_W'(COLS - 1));
    assign last_row  = (row_reg == ROW_W'(ROWS - 1));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        fill_next     = fill_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        load_scrolled = 1'b0;
        load_cell     = '0;
        we            = 1'b0;
        waddr         = cur_addr;
        wdata         = {q_op.attribute, q_op.char_code};
        raddr         = cell_addr(q_op.row, q_op.col);

        unique case (state_reg)
            ST_INIT:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = RESET_CELL;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_op.kind)
                        OP_PUT:
                        begin
                            we = 1'b1;
                            if (last_col)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                    load     = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                                load     = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                                load     = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            load = 1'b1;
                            if (col_reg != '0)
                            begin
                                we       = 1'b1;
                                waddr    = cur_addr - ADDR_W'(1);
                                wdata    = {erase_attr, SPACE_CHAR};
                                col_next = col_reg - COL_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            fill_next  = {clear_attr, SPACE_CHAR};
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        OP_SETCUR:
                        begin
                            col_next = q_op.col;
                            row_next = q_op.row;
                            load     = 1'b1;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                load       = 1'b1;
                load_cell  = rdata;
                state_next = ST_IDLE;
            end

            ST_FILL:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = fill_reg;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_SCROLL:
            begin
                // Each cell is read one row below its target and written in the next cycle.
                raddr = (cnt_reg < SCROLL_LEN) ? cnt_reg + ADDR_W'(COLS) : '0;
                we    = (cnt_reg != '0);
                waddr = cnt_reg - ADDR_W'(1);
                wdata = rdata;
                if (cnt_reg == SCROLL_LEN)
                begin
                    cnt_next      = '0;
                    load          = 1'b1;
                    load_scrolled = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_next.pos        = to_pos(cell_addr(row_next, col_next));
        out_next.cell_value = load_cell;
        out_next.scrolled   = load_scrolled;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg <= fill_next;
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result       = out_reg;
    assign status.init    = (state_reg == ST_INIT);
    assign status.busy    = (state_reg != ST_IDLE);
    assign status.cur_col = col_reg;
    assign status.cur_row = row_reg;

endmodule

`default_nettype wire

### rtl/text_console_writer_unit.sv
// Top level of the text console writer: ports, configuration registers and checks.
//
//   Channel   Direction  Transfer when                      Contents
//   s_axis    in         s_axis_tvalid and s_axis_tready    one console command
//   m_axis    out        m_axis_tvalid and m_axis_tready    cursor, cell value, scroll flag
//   APB       in/out     psel, penable, pwrite and pready   attribute registers
//
// Put, backspace, set cursor and unused commands are executed straight from the idle state,
// and a read passes through a read state, as the screen store has a registered read port.
// A clear and a put or newline that scrolls run a sweep over the screen store, one cell
// per cycle after the cycle that takes the command.
// After reset a clearing pass over all 2000 cells runs, during which no beat is accepted.
// A two-entry command queue lets the input side accept beats while a sweep runs
// or while a result waits in the output register.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit
    import tcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[2:0], char_code[10:3], attribute[18:11], column[25:19], row[30:26], zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // cursor_position[10:0], cell_value[26:11], scrolled[27], zero above
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [ATTR_W-1:0] clear_attr_reg, clear_attr_next;
    logic [ATTR_W-1:0] erase_attr_reg, erase_attr_next;
    logic              cfg_write;

    logic              q_push;
    op_t               q_push_op;
    logic              q_pop;
    op_t               q_op;
    logic              q_empty;
    logic              q_full;
    result_t           result;
    back_status_t      back_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? APB_DATA_W'(erase_attr_reg) : APB_DATA_W'(clear_attr_reg);

    always_comb
    begin
        clear_attr_next = clear_attr_reg;
        erase_attr_next = erase_attr_reg;
        if (cfg_write)
        begin
            if (paddr[2])
            begin
                erase_attr_next = pwdata[ATTR_W-1:0];
            end
            else
            begin
                clear_attr_next = pwdata[ATTR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_attr_reg <= RESET_CLEAR_ATTR;
            erase_attr_reg <= RESET_ERASE_ATTR;
        end
        else
        begin
            clear_attr_reg <= clear_attr_next;
            erase_attr_reg <= erase_attr_next;
        end
    end

    tcw_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .hold          (back_stat.init),
        .push          (q_push),
        .push_op       (q_push_op)
    );

    tcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .pop_op  (q_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    tcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_op       (q_op),
        .q_pop      (q_pop),
        .clear_attr (clear_attr_reg),
        .erase_attr (erase_attr_reg),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (result),
        .status     (back_stat)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result.scrolled, result.cell_value, result.pos};

    `TCW_ASSERT_IMP(a_cursor_in_range, 1'b1,
        (int'(back_stat.cur_col) < COLS) && (int'(back_stat.cur_row) < ROWS),
        "cursor left the screen")
    `TCW_ASSERT_IMP(a_scroll_on_last_row, m_axis_tvalid && m_axis_tdata[OUT_SCROLL_BIT],
        m_axis_tdata[POS_W-1:0] == to_pos(ADDR_W'((ROWS - 1) * COLS)),
        "scroll result not at the start of the last row")
    `TCW_ASSERT_IMP(a_no_pop_when_busy, back_stat.busy, !q_pop,
        "command taken while a sweep or read was running")
    `TCW_ASSERT_NXT(a_clear_starts_sweep, q_pop && (q_op.kind == OP_CLEAR),
        back_stat.busy && (back_stat.cur_col == '0) && (back_stat.cur_row == '0),
        "clear did not start a fill sweep")

endmodule

`default_nettype wire
